// File: rtl/core/rfd_pkg.sv
// shared types and constants of the rpc frame deframer
`timescale 1ns / 1ps

package rfd_pkg;

  // deframer phase
  typedef enum logic [1:0] {
    PhHunt  = 2'd0,
    PhFrame = 2'd1,
    PhSkip  = 2'd2
  } phase_e;

  // field tags, in frame order
  typedef enum logic [3:0] {
    FldLength    = 4'd0,
    FldIdLen     = 4'd1,
    FldId        = 4'd2,
    FldMethodLen = 4'd3,
    FldMethod    = 4'd4,
    FldErrCode   = 4'd5,
    FldInfoLen   = 4'd6,
    FldInfo      = 4'd7,
    FldPayload   = 4'd8,
    FldChecksum  = 4'd9,
    FldEnd       = 4'd10
  } field_e;

  // frame status reported on the last request of a frame
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadEnd  = 2'd1,
    StBadLen  = 2'd2,
    StOverrun = 2'd3
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CfgStartMarker = 2'd0;
  localparam logic [1:0] CfgEndMarker   = 2'd1;
  localparam logic [1:0] CfgMaxFrameLen = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0]  StartMarkerRst = 8'd2;
  localparam logic [7:0]  EndMarkerRst   = 8'd3;
  localparam logic [15:0] MaxFrameLenRst = 16'hffff;

  // fixed bytes of a frame: 24 header/trailer bytes plus two markers
  localparam int unsigned FixedOverhead = 24;
  localparam int unsigned MarkerBytes   = 2;
  localparam int unsigned FrameMin      = FixedOverhead + MarkerBytes;

  // bytes in a 32-bit field
  localparam int unsigned WordBytes = 4;

endpackage

// File: rtl/core/rpc_frame_deframer.sv
// rpc frame deframer: byte stream in, tagged field bytes and frame status out
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------------------
//  in       | input     | in_valid_i/in_ready_o | data_byte_i
//  out      | output    | out_valid_o/out_ready_i| field_tag_o byte_out_o word_value_o
//           |           |                       | word_valid_o frame_last_o status_o
//  cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i cfg_data_i
//
//  one byte per cycle while in_ready_o is high: each accepted byte updates the
//  frame state and, when it makes a result, loads the output register in the same cycle
//  the result of an accepted byte shows on the outputs in the next cycle
//  the input stays ready while the output register is empty or being taken
//  reset (rst_ni low, asynchronous) returns to hunting and restores the
//  configuration reset values; cfg writes are always taken
`timescale 1ns / 1ps

module rpc_frame_deframer
  import rfd_pkg::*;
#(
  parameter int unsigned POS_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  // tagged results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  field_tag_o,
  output logic [7:0]  byte_out_o,
  output logic [31:0] word_value_o,
  output logic        word_valid_o,
  output logic        frame_last_o,
  output logic [1:0]  status_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // largest frame position, 33 bits wide so that POS_BITS of 32 works
  localparam logic [32:0] PosMax = (33'd1 << POS_BITS) - 33'd1;

  // configuration registers
  logic [7:0]  start_marker_q;
  logic [7:0]  end_marker_q;
  logic [15:0] max_frame_len_q;

  // frame state, the word register keeps the low three bytes only
  phase_e              phase_q, phase_d;
  logic [POS_BITS-1:0] frame_pos_q, frame_pos_d;
  logic [POS_BITS-1:0] total_len_q, total_len_d;
  field_e              field_q, field_d;
  logic [POS_BITS-1:0] field_left_q, field_left_d;
  logic [23:0]         word_shift_q, word_shift_d;
  logic [POS_BITS-1:0] var_used_q, var_used_d;

  // output register
  logic        out_valid_q;
  logic [3:0]  field_tag_q, field_tag_d;
  logic [7:0]  byte_out_q;
  logic [31:0] word_value_q, word_value_d;
  logic        word_valid_q, word_valid_d;
  logic        frame_last_q, frame_last_d;
  status_e     status_q, status_d;

  logic                res_valid;
  logic                in_accept;
  logic [POS_BITS-1:0] pos_inc;
  logic [31:0]         word_new;
  logic [POS_BITS-1:0] left_dec;
  logic [POS_BITS-1:0] room;
  logic [32:0]         var_sum;
  logic                is_word;
  logic                bad_len;
  logic                overrun;
  logic [POS_BITS-1:0] pay_len;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // per-byte datapath terms
  assign pos_inc  = frame_pos_q + POS_BITS'(1);
  assign word_new = {word_shift_q, data_byte_i};
  assign left_dec = field_left_q - POS_BITS'(1);
  assign room     = total_len_q - POS_BITS'(FrameMin);
  assign var_sum  = {1'b0, word_new} + 33'(var_used_q);
  assign is_word  = (field_q == FldLength) || (field_q == FldIdLen) ||
                    (field_q == FldMethodLen) || (field_q == FldErrCode) ||
                    (field_q == FldInfoLen) || (field_q == FldChecksum);
  assign bad_len  = ({1'b0, word_new} < 33'(FrameMin)) ||
                    (word_new > 32'(max_frame_len_q)) ||
                    ({1'b0, word_new} > PosMax);
  assign overrun  = var_sum > 33'(room);

  // next frame state and result
  always_comb begin
    phase_d      = phase_q;
    frame_pos_d  = frame_pos_q;
    total_len_d  = total_len_q;
    field_d      = field_q;
    field_left_d = field_left_q;
    word_shift_d = word_shift_q;
    var_used_d   = var_used_q;
    res_valid    = 1'b0;
    field_tag_d  = field_q;
    word_value_d = '0;
    word_valid_d = 1'b0;
    frame_last_d = 1'b0;
    status_d     = StOk;
    pay_len      = '0;
    if (in_accept) begin
      unique case (phase_q)
        PhHunt: begin
          if (data_byte_i == start_marker_q) begin
            phase_d      = PhFrame;
            frame_pos_d  = POS_BITS'(1);
            total_len_d  = '0;
            var_used_d   = '0;
            field_d      = FldLength;
            field_left_d = POS_BITS'(WordBytes);
            word_shift_d = '0;
          end
        end
        PhSkip: begin
          frame_pos_d = pos_inc;
          if (pos_inc == total_len_q) begin
            phase_d      = PhHunt;
            res_valid    = 1'b1;
            field_tag_d  = FldEnd;
            frame_last_d = 1'b1;
            status_d     = StOverrun;
          end
        end
        PhFrame: begin
          frame_pos_d = pos_inc;
          res_valid   = 1'b1;
          if (field_q == FldEnd) begin
            frame_last_d = 1'b1;
            status_d     = (data_byte_i == end_marker_q) ? StOk : StBadEnd;
            phase_d      = PhHunt;
          end else begin
            if (is_word) begin
              word_shift_d = word_new[23:0];
            end
            field_left_d = left_dec;
            if (left_dec == '0) begin
              if (is_word) begin
                word_value_d = word_new;
                word_valid_d = 1'b1;
              end
              // field complete: check lengths and move to the next field
              unique case (field_q)
                FldLength: begin
                  total_len_d = word_new[POS_BITS-1:0];
                  if (bad_len) begin
                    frame_last_d = 1'b1;
                    status_d     = StBadLen;
                    phase_d      = PhHunt;
                  end else begin
                    field_d      = FldIdLen;
                    field_left_d = POS_BITS'(WordBytes);
                    word_shift_d = '0;
                  end
                end
                FldIdLen: begin
                  if (overrun) begin
                    phase_d = PhSkip;
                  end else begin
                    var_used_d = var_sum[POS_BITS-1:0];
                    if (word_new != '0) begin
                      field_d      = FldId;
                      field_left_d = word_new[POS_BITS-1:0];
                    end else begin
                      field_d      = FldMethodLen;
                      field_left_d = POS_BITS'(WordBytes);
                      word_shift_d = '0;
                    end
                  end
                end
                FldId: begin
                  field_d      = FldMethodLen;
                  field_left_d = POS_BITS'(WordBytes);
                  word_shift_d = '0;
                end
                FldMethodLen: begin
                  if (overrun) begin
                    phase_d = PhSkip;
                  end else begin
                    var_used_d = var_sum[POS_BITS-1:0];
                    if (word_new != '0) begin
                      field_d      = FldMethod;
                      field_left_d = word_new[POS_BITS-1:0];
                    end else begin
                      field_d      = FldErrCode;
                      field_left_d = POS_BITS'(WordBytes);
                      word_shift_d = '0;
                    end
                  end
                end
                FldMethod: begin
                  field_d      = FldErrCode;
                  field_left_d = POS_BITS'(WordBytes);
                  word_shift_d = '0;
                end
                FldErrCode: begin
                  field_d      = FldInfoLen;
                  field_left_d = POS_BITS'(WordBytes);
                  word_shift_d = '0;
                end
                FldInfoLen: begin
                  if (overrun) begin
                    phase_d = PhSkip;
                  end else begin
                    var_used_d = var_sum[POS_BITS-1:0];
                    pay_len    = room - var_sum[POS_BITS-1:0];
                    if (word_new != '0) begin
                      field_d      = FldInfo;
                      field_left_d = word_new[POS_BITS-1:0];
                    end else if (pay_len != '0) begin
                      field_d      = FldPayload;
                      field_left_d = pay_len;
                    end else begin
                      field_d      = FldChecksum;
                      field_left_d = POS_BITS'(WordBytes);
                      word_shift_d = '0;
                    end
                  end
                end
                FldInfo: begin
                  pay_len = room - var_used_q;
                  if (pay_len != '0) begin
                    field_d      = FldPayload;
                    field_left_d = pay_len;
                  end else begin
                    field_d      = FldChecksum;
                    field_left_d = POS_BITS'(WordBytes);
                    word_shift_d = '0;
                  end
                end
                FldPayload: begin
                  field_d      = FldChecksum;
                  field_left_d = POS_BITS'(WordBytes);
                  word_shift_d = '0;
                end
                default: begin
                  // checksum done, only the end marker is left
                  field_d      = FldEnd;
                  field_left_d = POS_BITS'(1);
                end
              endcase
            end
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q  <= StartMarkerRst;
      end_marker_q    <= EndMarkerRst;
      max_frame_len_q <= MaxFrameLenRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgStartMarker) begin
        start_marker_q <= cfg_data_i[7:0];
      end
      if (cfg_index_i == CfgEndMarker) begin
        end_marker_q <= cfg_data_i[7:0];
      end
      if (cfg_index_i == CfgMaxFrameLen) begin
        max_frame_len_q <= cfg_data_i;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      frame_pos_q  <= '0;
      total_len_q  <= '0;
      field_q      <= FldLength;
      field_left_q <= '0;
      word_shift_q <= '0;
      var_used_q   <= '0;
    end else begin
      phase_q      <= phase_d;
      frame_pos_q  <= frame_pos_d;
      total_len_q  <= total_len_d;
      field_q      <= field_d;
      field_left_q <= field_left_d;
      word_shift_q <= word_shift_d;
      var_used_q   <= var_used_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= res_valid;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      field_tag_q  <= field_tag_d;
      byte_out_q   <= data_byte_i;
      word_value_q <= word_value_d;
      word_valid_q <= word_valid_d;
      frame_last_q <= frame_last_d;
      status_q     <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign field_tag_o  = field_tag_q;
  assign byte_out_o   = byte_out_q;
  assign word_value_o = word_value_q;
  assign word_valid_o = word_valid_q;
  assign frame_last_o = frame_last_q;
  assign status_o     = status_q;

endmodule

// File: tb/sv/tb.sv
// testbench of the rpc frame deframer: framed byte streams checked against a built-in predictor
`timescale 1ns / 1ps

module tb;
  import rfd_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned HoldAtResult = 400;
  localparam int unsigned PhaseBytes   = 90;
  localparam logic [15:0] PosMax       = 16'hffff;
  // register index past the last register, writes to it are dropped
  localparam logic [1:0]  CfgSpare     = 2'd3;

  typedef enum logic [1:0] {
    FillZero,
    FillOnes,
    FillRand
  } fill_e;

  // one frame to send: declared total and field lengths, content and end byte
  typedef struct {
    int unsigned noise;
    logic [31:0] total;
    logic [31:0] id_len;
    logic [31:0] meth_len;
    logic [31:0] info_len;
    fill_e       fill;
    bit          bad_end;
    bit          typed;
    status_e     exp_st;
  } frame_spec_t;

  // one tagged byte as the deframer reports it
  typedef struct {
    field_e      tag;
    logic [7:0]  data;
    logic [31:0] word;
    logic        word_ok;
    logic        last;
    status_e     st;
  } tagged_byte_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [3:0]  field_tag_o;
  logic [7:0]  byte_out_o;
  logic [31:0] word_value_o;
  logic        word_valid_o;
  logic        frame_last_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i  = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i  = CfgStartMarker;
  logic [15:0] cfg_data_i   = '0;

  rpc_frame_deframer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .field_tag_o  (field_tag_o),
    .byte_out_o   (byte_out_o),
    .word_value_o (word_value_o),
    .word_valid_o (word_valid_o),
    .frame_last_o (frame_last_o),
    .status_o     (status_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // deframe state mirrored from the block, with its own register copies
  phase_e      fr_phase = PhHunt;
  logic [15:0] fr_pos   = '0;
  logic [31:0] fr_total = '0;
  field_e      fr_field = FldLength;
  logic [31:0] fr_left  = '0;
  logic [31:0] fr_shift = '0;
  logic [31:0] fr_var   = '0;
  logic [7:0]  reg_start = StartMarkerRst;
  logic [7:0]  reg_end   = EndMarkerRst;
  logic [15:0] reg_max   = MaxFrameLenRst;

  tagged_byte_t pending_fields[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles     = 0;
  int unsigned  bytes_sent = 0;
  bit           calm       = 1'b0;
  bit           seen_last  = 1'b0;
  status_e      seen_st    = StOk;

  // settings the stimulus builds frames for
  logic [7:0]  gen_start = StartMarkerRst;
  logic [7:0]  gen_end   = EndMarkerRst;
  logic [15:0] gen_max   = MaxFrameLenRst;

  // frame under construction
  logic [7:0]  wire_bytes[$];
  longint      body_room;

  function automatic bit is_word_field(input field_e f);
    return f inside {FldLength, FldIdLen, FldMethodLen, FldErrCode, FldInfoLen, FldChecksum};
  endfunction

  // step to the next field that holds bytes, skipping empty ones
  function automatic void open_field(input int unsigned first);
    int unsigned f;
    f = first;
    fr_left = '0;
    while (fr_left == '0) begin
      if (f >= FldEnd) begin
        fr_field = FldEnd;
        fr_left  = 32'd1;
      end else begin
        fr_field = field_e'(4'(f));
        if (is_word_field(fr_field)) begin
          fr_left  = WordBytes;
          fr_shift = '0;
        end else if (fr_field == FldPayload) begin
          fr_left = fr_total - FrameMin - fr_var;
        end else begin
          fr_left = fr_shift;
        end
        f++;
      end
    end
  endfunction

  // expected result of one accepted byte, if it makes one
  function automatic void deframe_byte(input logic [7:0] b);
    tagged_byte_t r;
    logic [32:0]  sum;
    r = '{tag: FldLength, data: b, word: '0, word_ok: 1'b0, last: 1'b0, st: StOk};
    if (fr_phase == PhHunt) begin
      if (b == reg_start) begin
        fr_phase = PhFrame;
        fr_pos   = 16'd1;
        fr_total = '0;
        fr_var   = '0;
        open_field(FldLength);
      end
      return;
    end
    fr_pos = fr_pos + 16'd1;
    if (fr_phase == PhSkip) begin
      // overrun: silent until the byte at the declared frame end
      if ({16'b0, fr_pos} != fr_total) return;
      fr_phase = PhHunt;
      r.tag    = FldEnd;
      r.last   = 1'b1;
      r.st     = StOverrun;
    end else if (fr_field == FldEnd) begin
      r.tag    = FldEnd;
      r.last   = 1'b1;
      r.st     = (b == reg_end) ? StOk : StBadEnd;
      fr_phase = PhHunt;
    end else begin
      r.tag = fr_field;
      if (is_word_field(fr_field)) fr_shift = {fr_shift[23:0], b};
      fr_left = fr_left - 32'd1;
      if (fr_left == '0) begin
        if (is_word_field(fr_field)) begin
          r.word    = fr_shift;
          r.word_ok = 1'b1;
        end
        if (fr_field == FldLength) begin
          fr_total = fr_shift;
          if (fr_total < FrameMin || fr_total > reg_max || fr_total > PosMax) begin
            r.last   = 1'b1;
            r.st     = StBadLen;
            fr_phase = PhHunt;
          end
        end else if (fr_field inside {FldIdLen, FldMethodLen, FldInfoLen}) begin
          sum = {1'b0, fr_var} + {1'b0, fr_shift};
          if (sum > {1'b0, fr_total} - FrameMin) fr_phase = PhSkip;
          else fr_var = sum[31:0];
        end
        if (fr_phase == PhFrame) open_field(int'(fr_field) + 1);
      end
    end
    pending_fields = {pending_fields, r};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result check, register mirror and prediction, all on the sampled edge
  always @(posedge clk_i) begin
    tagged_byte_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_fields.size() == 0) begin
          $error("result with none pending: field_tag 0x%0h byte_out 0x%0h",
                 field_tag_o, byte_out_o);
          mismatches++;
        end else begin
          want = pending_fields.pop_front();
          check_field("field_tag", want.tag, field_tag_o);
          check_field("byte_out", want.data, byte_out_o);
          check_field("word_value", want.word, word_value_o);
          check_field("word_valid", want.word_ok, word_valid_o);
          check_field("frame_last", want.last, frame_last_o);
          check_field("status", want.st, status_o);
        end
        if (frame_last_o) begin
          seen_last = 1'b1;
          seen_st   = status_e'(status_o);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgStartMarker: reg_start = cfg_data_i[7:0];
          CfgEndMarker:   reg_end   = cfg_data_i[7:0];
          CfgMaxFrameLen: reg_max   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) deframe_byte(data_byte_i);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: random stall per request, one long hold-off to back up the input
  initial begin
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken == HoldAtResult) gap = LongHold;
      else gap = calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  function automatic logic [7:0] fill_byte(input fill_e f);
    case (f)
      FillZero: return 8'h00;
      FillOnes: return 8'hff;
      default:  return 8'($urandom);
    endcase
  endfunction

  // frame body bytes never pass the slot of the end marker
  function automatic void put_byte(input logic [7:0] b);
    if (body_room > 0) begin
      wire_bytes = {wire_bytes, b};
      body_room--;
    end
  endfunction

  function automatic void put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8]);
  endfunction

  function automatic void put_fill(input longint n, input fill_e f);
    for (longint k = 0; k < n && body_room > 0; k++) put_byte(fill_byte(f));
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == gen_start) b = 8'($urandom);
    return b;
  endfunction

  // sender: random gap per request, valid held until taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // exactly total bytes for an accepted length, else start and length only
  task automatic send_frame(input frame_spec_t fs);
    logic [7:0] tail;
    wire_bytes = {};
    repeat (fs.noise) wire_bytes = {wire_bytes, noise_byte()};
    wire_bytes = {wire_bytes, gen_start};
    for (int i = 3; i >= 0; i--) wire_bytes = {wire_bytes, fs.total[8*i +: 8]};
    if (fs.total >= FrameMin && fs.total <= gen_max && fs.total <= PosMax) begin
      body_room = longint'(fs.total) - 6;
      put_word(fs.id_len);
      put_fill(fs.id_len, fs.fill);
      put_word(fs.meth_len);
      put_fill(fs.meth_len, fs.fill);
      put_fill(WordBytes, fs.fill);
      put_word(fs.info_len);
      put_fill(fs.info_len, fs.fill);
      // payload is whatever is left in front of the checksum
      put_fill(body_room - WordBytes, fs.fill);
      put_fill(WordBytes, fs.fill);
      tail = fs.bad_end ? gen_end + 8'($urandom_range(1, 255)) : gen_end;
      wire_bytes = {wire_bytes, tail};
    end
    foreach (wire_bytes[i]) send_byte(wire_bytes[i]);
  endtask

  // sender pause until every pending result has come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register write request, valid left high for back-to-back writes
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // mostly well-formed frames with random content, the rest broken
  function automatic frame_spec_t rand_frame();
    frame_spec_t fs;
    logic [31:0] room;
    logic [31:0] over;
    int unsigned pay;
    int unsigned pick;
    fs.noise    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    fs.fill     = ($urandom_range(0, 9) < 8) ? FillRand
                : ($urandom_range(0, 1) ? FillOnes : FillZero);
    fs.bad_end  = 1'b0;
    fs.typed    = 1'b0;
    fs.exp_st   = StOk;
    fs.id_len   = $urandom_range(0, 4);
    fs.meth_len = $urandom_range(0, 4);
    fs.info_len = $urandom_range(0, 4);
    pay = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 200) : $urandom_range(0, 8);
    fs.total = FrameMin + fs.id_len + fs.meth_len + fs.info_len + pay;
    if (fs.total > gen_max) begin
      fs.id_len   = '0;
      fs.meth_len = '0;
      fs.info_len = '0;
      fs.total    = FrameMin;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      fs.bad_end = 1'b1;
    end else if (pick < 20) begin
      case ($urandom_range(0, 2))
        0:       fs.total = $urandom_range(0, FrameMin - 1);
        1:       fs.total = gen_max + $urandom_range(1, 300);
        default: fs.total = $urandom() | 32'h0001_0000;
      endcase
    end else if (pick < 30) begin
      room = fs.total - FrameMin;
      over = ($urandom_range(0, 3) == 0) ? $urandom() : room + $urandom_range(1, 3);
      case ($urandom_range(0, 2))
        0:       fs.id_len   = over;
        1:       fs.meth_len = over;
        default: fs.info_len = over;
      endcase
    end
    return fs;
  endfunction

  // one register setting, then random frames until enough bytes went in
  task automatic run_phase(input logic [7:0] s, input logic [7:0] e, input logic [15:0] m,
                           input bit spare);
    int unsigned first;
    wait_idle();
    if (spare) write_reg(CfgSpare, 16'($urandom));
    write_reg(CfgStartMarker, {8'($urandom), s});
    write_reg(CfgEndMarker, {8'($urandom), e});
    write_reg(CfgMaxFrameLen, m);
    cfg_valid_i <= 1'b0;
    gen_start = s;
    gen_end   = e;
    gen_max   = m;
    first = bytes_sent;
    while (bytes_sent - first < PhaseBytes) begin
      calm = ($urandom_range(0, 5) == 0);
      send_frame(rand_frame());
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
  endtask

  // directed frames at the reset register values
  frame_spec_t directed_frames[14] = '{
    // minimal frame, every variable field empty
    '{0, 32'd26, 32'd0, 32'd0, 32'd0, FillZero, 1'b0, 1'b1, StOk},
    '{0, 32'd26, 32'd0, 32'd0, 32'd0, FillOnes, 1'b0, 1'b1, StOk},
    // noise ahead of the start marker, one byte in every field
    '{2, 32'd30, 32'd1, 32'd1, 32'd1, FillOnes, 1'b0, 1'b1, StOk},
    '{0, 32'd40, 32'd3, 32'd2, 32'd4, FillRand, 1'b0, 1'b0, StOk},
    '{0, 32'd34, 32'd0, 32'd0, 32'd0, FillRand, 1'b0, 1'b0, StOk},
    // variable fields fill the frame exactly, no payload
    '{0, 32'd36, 32'd4, 32'd4, 32'd2, FillOnes, 1'b0, 1'b1, StOk},
    '{1, 32'd30, 32'd0, 32'd2, 32'd0, FillRand, 1'b1, 1'b1, StBadEnd},
    // total length out of range
    '{0, 32'd25, 32'd0, 32'd0, 32'd0, FillZero, 1'b0, 1'b1, StBadLen},
    '{0, 32'd0, 32'd0, 32'd0, 32'd0, FillZero, 1'b0, 1'b1, StBadLen},
    '{0, 32'hffff_ffff, 32'd0, 32'd0, 32'd0, FillZero, 1'b0, 1'b1, StBadLen},
    '{0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, FillZero, 1'b0, 1'b1, StBadLen},
    // id, method and info lengths running past the frame
    '{0, 32'd30, 32'hffff_ffff, 32'd0, 32'd0, FillRand, 1'b0, 1'b1, StOverrun},
    '{0, 32'd30, 32'd2, 32'd3, 32'd0, FillOnes, 1'b0, 1'b1, StOverrun},
    '{0, 32'd31, 32'd1, 32'd1, 32'd4, FillZero, 1'b0, 1'b1, StOverrun}
  };

  // stimulus
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_frames[i]) begin
      seen_last = 1'b0;
      send_frame(directed_frames[i]);
      wait_idle();
      if (directed_frames[i].typed) begin
        check_field("frame_last", 32'd1, seen_last);
        check_field("status", directed_frames[i].exp_st, seen_st);
      end
    end

    // register extremes, then a random setting, then back to reset values
    run_phase(8'h00, 8'hff, 16'(FrameMin), 1'b0);
    run_phase(8'hff, 8'h00, 16'hffff, 1'b0);
    run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(FrameMin, 300)), 1'b1);
    run_phase(StartMarkerRst, EndMarkerRst, MaxFrameLenRst, 1'b0);

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
